// ----- sv/rvx_pkg.sv -----
// Shared types, codes and decode helpers for the RV64I executor.
package rvx_pkg;

    localparam logic [31:0] HALT_WORD = 32'hfeedfeed;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    typedef enum logic [2:0] {
        ST_EXECUTED = 3'd0,
        ST_AWAIT    = 3'd1,
        ST_HALTED   = 3'd2,
        ST_ILLEGAL  = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } mem_op_t;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1b;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3b;

    localparam logic [6:0] F7_ZERO = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [5:0] H6_SRA  = 6'h10;

    // One queued item, as classified by the front end.
    typedef struct packed {
        logic        kind;
        logic [31:0] word;
        logic [63:0] load_data;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] next_pc;
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [63:0] mem_address;
        logic [63:0] store_data;
        logic        rd_write;
        logic [4:0]  rd_index;
        logic [63:0] rd_value;
    } result_t;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

// ----- sv/rvx_front.sv -----
// Input stage: accepts items into a short queue ahead of the execute stage.
module rvx_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  rvx_pkg::item_t in_item,
    output logic          q_valid,
    input  logic          q_take,
    output rvx_pkg::item_t q_item
);
    import rvx_pkg::*;

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wptr_reg, rptr_reg;
    logic [QUEUE_AW:0]      count_reg;
    logic                   push, pop;

    assign s_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign pop      = q_take && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !pop) else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not grow on push");
endmodule

// ----- sv/rvx_exec.sv -----
// Execute stage: architectural state, decode and one result per item.
module rvx_exec (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [63:0]     cfg_wdata,
    input  logic            q_valid,
    output logic            q_take,
    input  rvx_pkg::item_t  q_item,
    output logic            r_valid,
    input  logic            r_ready,
    output rvx_pkg::result_t r_data
);
    import rvx_pkg::*;

    logic [63:0] rf_reg [32];
    logic [63:0] pc_reg;
    logic        pend_reg;
    logic [4:0]  prd_reg;
    logic [2:0]  pf3_reg;
    logic        stop_reg;
    logic        rv_reg;
    result_t     res_reg;

    result_t     res;
    logic        fire;
    logic        wr, ok;
    logic [63:0] a, b, immi, imms, immb, immj, val, npc, ldv;
    logic [31:0] w;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [5:0]  hi6, sh;
    logic [31:0] a32, w32;
    logic        taken;

    assign q_take = q_valid && (!rv_reg || r_ready);
    assign fire   = q_take;
    assign r_valid = rv_reg;
    assign r_data  = res_reg;

    assign w    = q_item.word;
    assign op   = w[6:0];
    assign rd   = w[11:7];
    assign f3   = w[14:12];
    assign f7   = w[31:25];
    assign hi6  = w[31:26];
    assign a    = (w[19:15] == 5'd0) ? 64'd0 : rf_reg[w[19:15]];
    assign b    = (w[24:20] == 5'd0) ? 64'd0 : rf_reg[w[24:20]];
    assign immi = {{52{w[31]}}, w[31:20]};
    assign imms = {{52{w[31]}}, w[31:25], w[11:7]};
    assign immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    always_comb begin
        case (pf3_reg)
            3'd0:    ldv = {{56{q_item.load_data[7]}}, q_item.load_data[7:0]};
            3'd1:    ldv = {{48{q_item.load_data[15]}}, q_item.load_data[15:0]};
            3'd2:    ldv = sx32(q_item.load_data[31:0]);
            3'd4:    ldv = {56'd0, q_item.load_data[7:0]};
            3'd5:    ldv = {48'd0, q_item.load_data[15:0]};
            3'd6:    ldv = {32'd0, q_item.load_data[31:0]};
            default: ldv = q_item.load_data;
        endcase
    end

    always_comb begin
        res         = '0;
        res.status  = ST_IGNORED;
        res.next_pc = pc_reg;
        wr    = 1'b0;
        ok    = 1'b1;
        val   = '0;
        npc   = pc_reg + 64'd4;
        taken = 1'b0;
        sh    = 6'd0;
        a32   = a[31:0];
        w32   = 32'd0;
        case (op)
            OP_LUI:   begin wr = 1'b1; val = sx32({w[31:12], 12'd0}); end
            OP_AUIPC: begin wr = 1'b1; val = pc_reg + sx32({w[31:12], 12'd0}); end
            OP_JAL:   begin wr = 1'b1; val = pc_reg + 64'd4; npc = pc_reg + immj; end
            OP_JALR: begin
                if (f3 != 3'd0) ok = 1'b0;
                wr = 1'b1; val = pc_reg + 64'd4;
                npc = (a + immi) & ~64'd1;
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: taken = (a == b);
                    3'd1: taken = (a != b);
                    3'd4: taken = ($signed(a) < $signed(b));
                    3'd5: taken = ($signed(a) >= $signed(b));
                    3'd6: taken = (a < b);
                    3'd7: taken = (a >= b);
                    default: ok = 1'b0;
                endcase
                if (taken) npc = pc_reg + immb;
            end
            OP_LOAD:  if (f3 == 3'd7) ok = 1'b0;
            OP_STORE: if (f3[2]) ok = 1'b0;
            OP_IMM: begin
                wr = 1'b1;
                sh = w[25:20];
                case (f3)
                    3'd0: val = a + immi;
                    3'd1: begin if (hi6 != 6'd0) ok = 1'b0; val = a << sh; end
                    3'd2: val = {63'd0, $signed(a) < $signed(immi)};
                    3'd3: val = {63'd0, a < immi};
                    3'd4: val = a ^ immi;
                    3'd5: begin
                        if (hi6 == 6'd0) val = a >> sh;
                        else if (hi6 == H6_SRA) val = $unsigned($signed(a) >>> sh);
                        else ok = 1'b0;
                    end
                    3'd6: val = a | immi;
                    default: val = a & immi;
                endcase
            end
            OP_IMM32, OP_REG32: begin
                wr = 1'b1;
                sh = (op == OP_IMM32) ? {1'b0, w[24:20]} : {1'b0, b[4:0]};
                if (op == OP_IMM32 && f3 == 3'd0) w32 = a32 + immi[31:0];
                else if (op == OP_REG32 && f7 == F7_ZERO && f3 == 3'd0) w32 = a32 + b[31:0];
                else if (op == OP_REG32 && f7 == F7_ALT && f3 == 3'd0) w32 = a32 - b[31:0];
                else if (f7 == F7_ZERO && f3 == 3'd1) w32 = a32 << sh[4:0];
                else if (f7 == F7_ZERO && f3 == 3'd5) w32 = a32 >> sh[4:0];
                else if (f7 == F7_ALT && f3 == 3'd5) w32 = $unsigned($signed(a32) >>> sh[4:0]);
                else ok = 1'b0;
                val = sx32(w32);
            end
            OP_REG: begin
                wr = 1'b1;
                sh = b[5:0];
                if (f7 == F7_ZERO) begin
                    case (f3)
                        3'd0: val = a + b;
                        3'd1: val = a << sh;
                        3'd2: val = {63'd0, $signed(a) < $signed(b)};
                        3'd3: val = {63'd0, a < b};
                        3'd4: val = a ^ b;
                        3'd5: val = a >> sh;
                        3'd6: val = a | b;
                        default: val = a & b;
                    endcase
                end else if (f7 == F7_ALT && f3 == 3'd0) val = a - b;
                else if (f7 == F7_ALT && f3 == 3'd5) val = $unsigned($signed(a) >>> sh);
                else ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase

        if (stop_reg) begin
            // Everything is ignored until reset.
        end else if (q_item.kind) begin
            if (pend_reg) begin
                res.status = ST_EXECUTED;
                if (prd_reg != 5'd0) begin
                    res.rd_write = 1'b1;
                    res.rd_index = prd_reg;
                    res.rd_value = ldv;
                end
            end
        end else if (pend_reg) begin
            // A fetch while a load is outstanding is dropped.
        end else if (w == HALT_WORD) begin
            res.status = ST_HALTED;
        end else if (!ok) begin
            res.status = ST_ILLEGAL;
        end else if (op == OP_LOAD) begin
            res.status      = ST_AWAIT;
            res.next_pc     = npc;
            res.mem_op      = MEM_LOAD;
            res.mem_size    = f3[1:0];
            res.mem_address = a + immi;
        end else begin
            res.status  = ST_EXECUTED;
            res.next_pc = npc;
            if (op == OP_STORE) begin
                res.mem_op      = MEM_STORE;
                res.mem_size    = f3[1:0];
                res.mem_address = a + imms;
                case (f3[1:0])
                    2'd0:    res.store_data = {56'd0, b[7:0]};
                    2'd1:    res.store_data = {48'd0, b[15:0]};
                    2'd2:    res.store_data = {32'd0, b[31:0]};
                    default: res.store_data = b;
                endcase
            end
            if (wr && rd != 5'd0) begin
                res.rd_write = 1'b1;
                res.rd_index = rd;
                res.rd_value = val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
        end else if (fire && res.rd_write) begin
            rf_reg[res.rd_index] <= res.rd_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) res_reg <= res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            pend_reg <= 1'b0;
            prd_reg  <= '0;
            pf3_reg  <= '0;
            stop_reg <= 1'b0;
            rv_reg   <= 1'b0;
        end else begin
            if (cfg_we) pc_reg <= cfg_wdata;
            else if (fire) pc_reg <= res.next_pc;
            if (fire) begin
                if (res.status == ST_AWAIT) begin
                    pend_reg <= 1'b1;
                    prd_reg  <= rd;
                    pf3_reg  <= f3;
                end else if (q_item.kind && res.status == ST_EXECUTED) begin
                    pend_reg <= 1'b0;
                end
                if (res.status == ST_HALTED || res.status == ST_ILLEGAL) stop_reg <= 1'b1;
            end
            if (fire) rv_reg <= 1'b1;
            else if (r_ready) rv_reg <= 1'b0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (r_valid && !r_ready) |=> (r_valid && $stable(r_data)))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(stop_reg) |-> stop_reg) else $error("stopped flag cleared");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && stop_reg) |=> (res_reg.status == ST_IGNORED))
        else $error("stopped core executed an item");
endmodule

// ----- sv/rv64i_instruction_executor_core.sv -----
// RV64I executor top level: input queue, execute stage and result register.
// One item is taken per cycle when the result side keeps up; each item passes
// through the two-entry input queue and then the execute stage, whose
// register file is written at the same edge that retires an item, so
// dependent instructions run back to back. Each result is held in the result
// register until taken. Asserting cfg_we loads the program counter from cfg_wdata;
// write it only while idle.
module rv64i_instruction_executor_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // instruction_word[31:0], load_data[95:32]
    input  logic         s_tuser,  // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [271:0] m_tdata   // status, next_pc, mem_op, mem_size, mem_address,
                                   // store_data, rd_write, rd_index, rd_value; 3 pad
);
    import rvx_pkg::*;

    item_t   in_item, q_item;
    logic    q_valid, q_take;
    result_t r;

    assign in_item.kind      = s_tuser;
    assign in_item.word      = s_tdata[31:0];
    assign in_item.load_data = s_tdata[95:32];

    rvx_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
    );

    rvx_exec u_exec (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r)
    );

    assign m_tdata = {3'd0, r.rd_value, r.rd_index, r.rd_write, r.store_data,
                      r.mem_address, r.mem_size, r.mem_op, r.next_pc, r.status};
endmodule
